// ===== rtl/cfhb_pkg.sv =====
`default_nettype none

package cfhb_pkg;

  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = SAMPLE_W + 1;
  localparam int PROD_W     = SUM_W + SAMPLE_W;
  localparam int COEF_W     = 64;
  localparam int NUM_TAPS   = 16;
  localparam int TAP_AW     = $clog2(NUM_TAPS);
  localparam int NUM_GROUPS = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int PC_W       = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_3 = 3'd4;

  localparam logic [PC_W-1:0] PC_WAIT     = 5'd0;
  localparam logic [PC_W-1:0] PC_FIR_0    = 5'd1;
  localparam logic [PC_W-1:0] PC_FIR_LAST = 5'd16;
  localparam logic [PC_W-1:0] PC_FIR_DONE = 5'd20;
  localparam logic [PC_W-1:0] PC_HB_0     = 5'd21;
  localparam logic [PC_W-1:0] PC_HB_LAST  = 5'd24;
  localparam logic [PC_W-1:0] PC_HB_CTR   = 5'd25;
  localparam logic [PC_W-1:0] PC_HB_DONE  = 5'd29;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WAIT,
    OP_MAC,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               jmp_mode;
    logic [PC_W-1:0]    target;
    logic [HIST_AW-1:0] off_a;
    logic [HIST_AW-1:0] off_b;
    logic               b_en;
    logic               unscaled;
    logic [TAP_AW-1:0]  tap_idx;
    logic               push_second;
  } ctrl_t;

  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t           w;
    logic [PC_W-1:0] j;
    logic [PC_W-1:0] k;
    w = '0;
    j = PC_W'(pc - PC_FIR_0);
    k = PC_W'(pc - PC_HB_0);
    if (pc == PC_WAIT) begin
      w.op       = OP_WAIT;
      w.jmp_mode = 1'b1;
      w.target   = PC_HB_0;
    end else if (pc >= PC_FIR_0 && pc <= PC_FIR_LAST) begin
      w.op      = OP_MAC;
      w.tap_idx = j[TAP_AW-1:0];
      if (j == 5'd15) begin
        w.off_a = 5'd16;
        w.b_en  = 1'b0;
      end else begin
        w.off_a = 5'(j + 5'd1);
        w.off_b = 5'(5'd31 - j);
        w.b_en  = 1'b1;
      end
    end else if (pc == PC_FIR_DONE) begin
      w.op     = OP_FINISH;
      w.target = PC_WAIT;
    end else if (pc >= PC_HB_0 && pc <= PC_HB_LAST) begin
      w.op      = OP_MAC;
      w.tap_idx = k[TAP_AW-1:0];
      w.off_a   = 5'(5'd17 + (k << 1));
      w.off_b   = 5'(5'd31 - (k << 1));
      w.b_en    = 1'b1;
    end else if (pc == PC_HB_CTR) begin
      w.op       = OP_MAC;
      w.off_a    = 5'd24;
      w.unscaled = 1'b1;
    end else if (pc == PC_HB_DONE) begin
      w.op          = OP_FINISH;
      w.target      = PC_WAIT;
      w.push_second = 1'b1;
    end else begin
      w.op = OP_NOP;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/complex_symmetric_fir_halfband_q15.sv =====
// Complex Q15 folded symmetric FIR and halfband decimator. A small microcode
// program steps one shared complex multiply-accumulate datapath over the folded
// taps, reading two history entries a cycle from a 32-entry circular buffer.
// A FIR word (one sample) runs from acceptance to a registered result through
// the 16 folded taps, a drain of the read/add/multiply/accumulate pipeline and
// one output step. A halfband word (two samples) runs through four taps, the
// unscaled centre entry, the same drain and the output step, which also pushes
// the second sample. A new word is taken only in the wait step, after the output
// step of the last one. The output step holds while an earlier result still
// waits on the output. The next word is accepted the cycle after a result is
// registered, while that result still waits on the output. Each product is
// floored by 2^15 and the sum wraps to 16 bits; history is zero after reset.
`default_nettype none

module complex_symmetric_fir_halfband_q15 (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [15:0]   in_first_re,
  input  wire logic signed [15:0]   in_first_im,
  input  wire logic signed [15:0]   in_second_re,
  input  wire logic signed [15:0]   in_second_im,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [15:0]        out_result_re,
  output logic signed [15:0]        out_result_im,
  input  wire logic                 cfg_wr_en,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [63:0]          cfg_data
);

  import cfhb_pkg::*;

  logic                         mode_r;
  logic [COEF_W-1:0]            coef_r [NUM_GROUPS];
  logic [PC_W-1:0]              pc_r;
  ctrl_t                        ctrl;
  logic                         in_fire;
  logic                         fin_go;
  logic                         push_go;
  logic [HIST_AW-1:0]           wptr_r;
  logic [HIST_DEPTH-1:0]        hist_vld_r;
  logic [2*SAMPLE_W-1:0]        hist_mem [HIST_DEPTH];
  logic [2*SAMPLE_W-1:0]        wr_data;
  logic [HIST_AW-1:0]           addr_a;
  logic [HIST_AW-1:0]           addr_b;
  logic signed [SAMPLE_W-1:0]   tap_val;
  logic signed [SAMPLE_W-1:0]   sec_re_r;
  logic signed [SAMPLE_W-1:0]   sec_im_r;

  logic [2*SAMPLE_W-1:0]        rd_a_r;
  logic [2*SAMPLE_W-1:0]        rd_b_r;
  logic                         rd_a_vld_r;
  logic                         rd_b_vld_r;
  logic                         s1_mac_r;
  logic                         s1_b_en_r;
  logic                         s1_unscaled_r;
  logic signed [SAMPLE_W-1:0]   s1_tap_r;

  logic signed [SAMPLE_W-1:0]   a_re;
  logic signed [SAMPLE_W-1:0]   a_im;
  logic signed [SAMPLE_W-1:0]   b_re;
  logic signed [SAMPLE_W-1:0]   b_im;
  logic                         s2_mac_r;
  logic                         s2_unscaled_r;
  logic signed [SAMPLE_W-1:0]   s2_tap_r;
  logic signed [SUM_W-1:0]      sum_re_r;
  logic signed [SUM_W-1:0]      sum_im_r;

  logic                         s3_mac_r;
  logic signed [PROD_W-1:0]     prod_re_r;
  logic signed [PROD_W-1:0]     prod_im_r;
  logic signed [PROD_W-1:0]     prod_re_nxt;
  logic signed [PROD_W-1:0]     prod_im_nxt;

  logic [SAMPLE_W-1:0]          acc_re_r;
  logic [SAMPLE_W-1:0]          acc_im_r;
  logic                         out_valid_r;
  logic [SAMPLE_W-1:0]          out_re_r;
  logic [SAMPLE_W-1:0]          out_im_r;

  assign ctrl     = ucode_rom(pc_r);
  assign in_ready = (ctrl.op == OP_WAIT);
  assign in_fire  = in_valid && in_ready;
  assign fin_go   = (ctrl.op == OP_FINISH) && (!out_valid_r || out_ready);
  assign push_go  = in_fire || (fin_go && ctrl.push_second);
  assign wr_data  = in_fire ? {in_first_re, in_first_im} : {sec_re_r, sec_im_r};
  assign addr_a   = HIST_AW'(wptr_r + ctrl.off_a);
  assign addr_b   = HIST_AW'(wptr_r + ctrl.off_b);
  assign tap_val  = $signed(coef_r[ctrl.tap_idx[TAP_AW-1:2]][{ctrl.tap_idx[1:0], 4'b0000} +: SAMPLE_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        coef_r[g] <= '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_data[0];
      end else if (cfg_index >= CFG_COEF_0 && cfg_index <= CFG_COEF_3) begin
        coef_r[2'(cfg_index - CFG_COEF_0)] <= cfg_data;
      end
    end
  end

  // Sequencer: hold on wait and finish until their handshake goes through.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      unique case (ctrl.op)
        OP_WAIT: begin
          if (in_fire) begin
            pc_r <= (ctrl.jmp_mode && mode_r) ? ctrl.target : PC_W'(pc_r + 1'b1);
          end
        end
        OP_FINISH: begin
          if (fin_go) begin
            pc_r <= ctrl.target;
          end
        end
        default: begin
          pc_r <= PC_W'(pc_r + 1'b1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sec_re_r <= in_second_re;
      sec_im_r <= in_second_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      hist_vld_r <= '0;
    end else if (push_go) begin
      wptr_r             <= HIST_AW'(wptr_r + 1'b1);
      hist_vld_r[wptr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      hist_mem[wptr_r] <= wr_data;
    end
    rd_a_r <= hist_mem[addr_a];
    rd_b_r <= hist_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_mac_r <= 1'b0;
      s2_mac_r <= 1'b0;
      s3_mac_r <= 1'b0;
    end else begin
      s1_mac_r <= (ctrl.op == OP_MAC);
      s2_mac_r <= s1_mac_r;
      s3_mac_r <= s2_mac_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_vld_r    <= hist_vld_r[addr_a];
    rd_b_vld_r    <= hist_vld_r[addr_b];
    s1_b_en_r     <= ctrl.b_en;
    s1_unscaled_r <= ctrl.unscaled;
    s1_tap_r      <= tap_val;
  end

  assign a_re = rd_a_vld_r ? $signed(rd_a_r[2*SAMPLE_W-1:SAMPLE_W]) : '0;
  assign a_im = rd_a_vld_r ? $signed(rd_a_r[SAMPLE_W-1:0]) : '0;
  assign b_re = (rd_b_vld_r && s1_b_en_r) ? $signed(rd_b_r[2*SAMPLE_W-1:SAMPLE_W]) : '0;
  assign b_im = (rd_b_vld_r && s1_b_en_r) ? $signed(rd_b_r[SAMPLE_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    sum_re_r      <= SUM_W'(a_re) + SUM_W'(b_re);
    sum_im_r      <= SUM_W'(a_im) + SUM_W'(b_im);
    s2_unscaled_r <= s1_unscaled_r;
    s2_tap_r      <= s1_tap_r;
  end

  // Centre entry: scale up by 2^15 so the common floor shift returns it intact.
  always_comb begin
    if (s2_unscaled_r) begin
      prod_re_nxt = $signed({sum_re_r[SUM_W-1], sum_re_r, 15'd0});
      prod_im_nxt = $signed({sum_im_r[SUM_W-1], sum_im_r, 15'd0});
    end else begin
      prod_re_nxt = sum_re_r * s2_tap_r;
      prod_im_nxt = sum_im_r * s2_tap_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_re_r <= prod_re_nxt;
    prod_im_r <= prod_im_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (s3_mac_r) begin
      acc_re_r <= acc_re_r + prod_re_r[15 +: SAMPLE_W];
      acc_im_r <= acc_im_r + prod_im_r[15 +: SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_re_r <= acc_re_r;
      out_im_r <= acc_im_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_re = $signed(out_re_r);
  assign out_result_im = $signed(out_im_r);

endmodule

`default_nettype wire

// ===== rtl/cfhb_chk.sv =====
`default_nettype none

module cfhb_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_result_re,
  input wire logic [15:0] out_result_im
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_re) && $stable(out_result_im))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in work");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result issued without returning to wait");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared straight after an accept");

endmodule

bind complex_symmetric_fir_halfband_q15 cfhb_chk u_cfhb_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_result_re (out_result_re),
  .out_result_im (out_result_im)
);

`default_nettype wire
